>>> sv/frga_pkg.sv
// Package for the font ROM glyph address pipeline: code constants and decode types.
package frga_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned IndexW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OpW    = 9;   // signed byte differences
  localparam int unsigned KaW    = 11;  // row stride constant
  localparam int unsigned KbW    = 4;   // column stride constant

  localparam logic [1:0] ModeAscii     = 2'd0;
  localparam logic [1:0] ModeAsciiSwap = 2'd1;
  localparam logic [1:0] ModeGb12      = 2'd2;
  localparam logic [1:0] ModeGb16      = 2'd3;

  localparam logic [KaW-1:0] Row94    = 11'd94;
  localparam logic [KaW-1:0] Row190   = 11'd190;
  localparam logic [KaW-1:0] Row96    = 11'd96;
  localparam logic [KaW-1:0] Area2Row = 11'd1260;
  localparam logic [KaW-1:0] Area1Row = 11'd10;
  localparam logic [KbW-1:0] ColOne   = 4'd1;
  localparam logic [KbW-1:0] ColTen   = 4'd10;

  localparam logic [IndexW-1:0] Sec5Base  = 32'd846;
  localparam logic [IndexW-1:0] Sec2Base  = 32'd1038;
  localparam logic [IndexW-1:0] Sec3Base  = 32'd1038 + 32'd6768;
  localparam logic [IndexW-1:0] Sec4Base  = 32'd1038 + 32'd12848;
  localparam logic [IndexW-1:0] FourBase  = 32'd1038 + 32'd21008;
  localparam logic [IndexW-1:0] Area2Base = 32'd1038 + 32'd21008 + 32'd161;
  localparam logic [IndexW-1:0] AsciiFirst = 32'h20;

  localparam logic [ByteW-1:0] Area1C3 = 8'hEE;

  typedef enum logic [3:0] {
    SecNone,
    SecAscii,
    SecOne,
    SecFive,
    SecTwo,
    SecThree,
    SecFour,
    SecArea1,
    SecArea2
  } sec_e;

  typedef struct packed {
    logic signed [OpW-1:0] a;
    logic [KaW-1:0]        ka;
    logic signed [OpW-1:0] b;
    logic [KbW-1:0]        kb;
    logic [IndexW-1:0]     c;
  } terms_t;

  // 0x7F is not a valid trail byte; codes above it close the gap
  function automatic logic [ByteW-1:0] skip_7f(input logic [ByteW-1:0] b);
    return (b > 8'h7F) ? b - 8'd1 : b;
  endfunction

endpackage

>>> sv/font_rom_glyph_address_top.sv
// Font ROM glyph address pipeline: code decode, index multiply-add, address multiply-add.
// Each beat passes the stage 1 to stage 5 registers in order; stage 5 is the output register.
// Throughput: one beat per cycle unless the output stalls; all five stages advance
//   together, set by the output register being free or taken in the same cycle.
// Reset: asynchronous, active low; clears the stage valid bits only.
// No state between beats beyond the pipeline itself.
module font_rom_glyph_address_top
  import frga_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [AddrW-1:0]  font_base_i,
  input  logic [ByteW-1:0]  glyph_bytes_i,
  input  logic [ByteW-1:0]  code_high_i,
  input  logic [ByteW-1:0]  code_low_i,
  input  logic [ByteW-1:0]  byte_three_i,
  input  logic [ByteW-1:0]  byte_four_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IndexW-1:0] glyph_index_o,
  output logic [AddrW-1:0]  rom_address_o
);

  logic advance;
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  // ---------------- stage 1: decode ----------------
  logic [15:0]       code;
  logic [15:0]       code_sw;
  logic [ByteW-1:0]  c1, c2, c3, c4, c2s;
  logic              four_byte;
  sec_e              sec;
  terms_t            terms_d;

  assign c1 = code_high_i;
  assign c2 = code_low_i;
  assign c3 = byte_three_i;
  assign c4 = byte_four_i;
  assign c2s = skip_7f(c2);
  assign code = {c1, c2};
  assign four_byte = (mode_i == ModeGb16);

  always_comb begin
    code_sw = code;
    if (mode_i == ModeAsciiSwap) begin
      case (code)
        16'h003B: code_sw = 16'h003A;
        16'h003A: code_sw = 16'h003B;
        16'h005F: code_sw = 16'h005E;
        16'h005E: code_sw = 16'h005F;
        default:  code_sw = code;
      endcase
    end
  end

  // sections 1/5 first; a later match of 2, 3, 4 or a four-byte area wins
  always_comb begin
    sec = SecNone;
    if (mode_i == ModeAscii || mode_i == ModeAsciiSwap) begin
      sec = SecAscii;
    end else if (c2 != 8'h7F) begin
      if (c1 >= 8'hA1 && c1 <= 8'hA9 && c2 >= 8'hA1) begin
        sec = SecOne;
      end else if (c1 >= 8'hA8 && c1 <= 8'hA9 && c2 < 8'hA1) begin
        sec = SecFive;
      end
      if (c1 >= 8'hB0 && c1 <= 8'hF7 && c2 >= 8'hA1) begin
        sec = SecTwo;
      end else if (c1 < 8'hA1 && c1 >= 8'h81 && c2 >= 8'h40) begin
        sec = SecThree;
      end else if (c1 >= 8'hAA && c2 < 8'hA1) begin
        sec = SecFour;
      end else if (four_byte && c1 == 8'h81 && c2 >= 8'h39) begin
        sec = SecArea1;
      end else if (four_byte && c1 == 8'h82) begin
        sec = SecArea2;
      end
    end
  end

  always_comb begin
    terms_d = '0;
    terms_d.kb = ColOne;
    unique case (sec)
      SecNone: begin
        terms_d = '0;
      end
      SecAscii: begin
        terms_d.c = {16'd0, code_sw} - AsciiFirst;
      end
      SecOne: begin
        terms_d.a  = OpW'({1'b0, c1} - 9'h0A1);
        terms_d.ka = Row94;
        terms_d.b  = OpW'({1'b0, c2} - 9'h0A1);
      end
      SecFive: begin
        terms_d.a  = OpW'({1'b0, c1} - 9'h0A8);
        terms_d.ka = Row96;
        terms_d.b  = OpW'({1'b0, c2s} - 9'h040);
        terms_d.c  = Sec5Base;
      end
      SecTwo: begin
        terms_d.a  = OpW'({1'b0, c1} - 9'h0B0);
        terms_d.ka = Row94;
        terms_d.b  = OpW'({1'b0, c2} - 9'h0A1);
        terms_d.c  = Sec2Base;
      end
      SecThree: begin
        terms_d.a  = OpW'({1'b0, c1} - 9'h081);
        terms_d.ka = Row190;
        terms_d.b  = OpW'({1'b0, c2s} - 9'h040);
        terms_d.c  = Sec3Base;
      end
      SecFour: begin
        terms_d.a  = OpW'({1'b0, c1} - 9'h0AA);
        terms_d.ka = Row96;
        terms_d.b  = OpW'({1'b0, c2s} - 9'h040);
        terms_d.c  = Sec4Base;
      end
      SecArea1: begin
        terms_d.a  = OpW'({1'b0, c3} - {1'b0, Area1C3});
        terms_d.ka = Area1Row;
        terms_d.b  = OpW'({1'b0, c4} - 9'h039);
        terms_d.c  = FourBase;
      end
      SecArea2: begin
        terms_d.a  = OpW'({1'b0, c2} - 9'h030);
        terms_d.ka = Area2Row;
        terms_d.b  = OpW'({1'b0, c3} - 9'h081);
        terms_d.kb = ColTen;
        terms_d.c  = Area2Base + {24'd0, c4} - 32'd48;
      end
      default: begin
        terms_d = '0;
      end
    endcase
  end

  logic              s1_valid_q;
  terms_t            s1_terms_q;
  logic [AddrW-1:0]  s1_base_q;
  logic [ByteW-1:0]  s1_bytes_q;

  // ---------------- stage 2: products ----------------
  logic signed [OpW+KaW:0] p1_d;
  logic signed [OpW+KbW:0] p2_d;
  assign p1_d = (OpW+KaW+1)'(s1_terms_q.a) * (OpW+KaW+1)'($signed({1'b0, s1_terms_q.ka}));
  assign p2_d = (OpW+KbW+1)'(s1_terms_q.b) * (OpW+KbW+1)'($signed({1'b0, s1_terms_q.kb}));

  logic                    s2_valid_q;
  logic signed [OpW+KaW:0] s2_p1_q;
  logic signed [OpW+KbW:0] s2_p2_q;
  logic [IndexW-1:0]       s2_c_q;
  logic [AddrW-1:0]        s2_base_q;
  logic [ByteW-1:0]        s2_bytes_q;

  // ---------------- stage 3: index sum ----------------
  logic [IndexW-1:0] idx_d;
  assign idx_d = s2_c_q
               + {{(IndexW-OpW-KaW-1){s2_p1_q[OpW+KaW]}}, s2_p1_q}
               + {{(IndexW-OpW-KbW-1){s2_p2_q[OpW+KbW]}}, s2_p2_q};

  logic              s3_valid_q;
  logic [IndexW-1:0] s3_idx_q;
  logic [AddrW-1:0]  s3_base_q;
  logic [ByteW-1:0]  s3_bytes_q;

  // ---------------- stage 4: offset product, mod 2^24 ----------------
  logic [AddrW-1:0] prod_d;
  assign prod_d = s3_idx_q[AddrW-1:0] * {{(AddrW-ByteW){1'b0}}, s3_bytes_q};

  logic              s4_valid_q;
  logic [IndexW-1:0] s4_idx_q;
  logic [AddrW-1:0]  s4_prod_q;
  logic [AddrW-1:0]  s4_base_q;

  // ---------------- stage 5: address, output register ----------------
  logic              s5_valid_q;
  logic [IndexW-1:0] s5_idx_q;
  logic [AddrW-1:0]  s5_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_terms_q <= terms_d;
      s1_base_q  <= font_base_i;
      s1_bytes_q <= glyph_bytes_i;
      s2_p1_q    <= p1_d;
      s2_p2_q    <= p2_d;
      s2_c_q     <= s1_terms_q.c;
      s2_base_q  <= s1_base_q;
      s2_bytes_q <= s1_bytes_q;
      s3_idx_q   <= idx_d;
      s3_base_q  <= s2_base_q;
      s3_bytes_q <= s2_bytes_q;
      s4_idx_q   <= s3_idx_q;
      s4_prod_q  <= prod_d;
      s4_base_q  <= s3_base_q;
      s5_idx_q   <= s4_idx_q;
      s5_addr_q  <= s4_base_q + s4_prod_q;
    end
  end

  assign out_valid_o   = s5_valid_q;
  assign glyph_index_o = s5_idx_q;
  assign rom_address_o = s5_addr_q;

  // ---------------- assertions ----------------
  a_stage4_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s4_valid_q |=> out_valid_o)
    else $error("beat lost between stage 4 and output");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !s4_valid_q |=> !out_valid_o)
    else $error("output beat repeated");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(s3_idx_q) && $stable(s4_prod_q) && $stable(s2_valid_q))
    else $error("pipeline stage changed during stall");

endmodule

>>> tb/sv/tb_font_rom_glyph_address_top.sv
// Testbench for the font ROM glyph address pipeline: predicted index and address per beat.
`timescale 1ns / 1ps

module tb_font_rom_glyph_address_top;
  import frga_pkg::*;

  // glyph numbering constants of the GB18030 character ROM
  localparam logic [31:0] Sec1Row       = 32'd94;
  localparam logic [31:0] Sec3Row       = 32'd190;
  localparam logic [31:0] Sec45Row      = 32'd96;
  localparam logic [31:0] Sec5Start     = 32'd846;
  localparam logic [31:0] Sec2Start     = 32'd1038;
  localparam logic [31:0] Sec3Start     = 32'd1038 + 32'd6768;
  localparam logic [31:0] Sec4Start     = 32'd1038 + 32'd12848;
  localparam logic [31:0] FourStart     = 32'd1038 + 32'd21008;
  localparam logic [31:0] Area2Skip     = 32'd161;
  localparam logic [31:0] Area2Stride   = 32'd1260;
  localparam logic [31:0] Area1Lead3    = 32'hEE;
  localparam logic [31:0] FirstPrintable = 32'h20;
  localparam logic [31:0] TrailGap      = 32'h7F;

  // ascii codes exchanged by the symbol swap mode
  localparam logic [15:0] ColonCode      = 16'h3A;
  localparam logic [15:0] SemicolonCode  = 16'h3B;
  localparam logic [15:0] CaretCode      = 16'h5E;
  localparam logic [15:0] UnderscoreCode = 16'h5F;

  typedef struct packed {
    logic [1:0]       mode;
    logic [AddrW-1:0] font_base;
    logic [ByteW-1:0] glyph_bytes;
    logic [ByteW-1:0] code_high;
    logic [ByteW-1:0] code_low;
    logic [ByteW-1:0] byte_three;
    logic [ByteW-1:0] byte_four;
  } code_beat_t;

  typedef struct packed {
    code_beat_t        src;
    logic [IndexW-1:0] glyph_index;
    logic [AddrW-1:0]  rom_address;
  } glyph_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        mode_i;
  logic [AddrW-1:0]  font_base_i;
  logic [ByteW-1:0]  glyph_bytes_i;
  logic [ByteW-1:0]  code_high_i;
  logic [ByteW-1:0]  code_low_i;
  logic [ByteW-1:0]  byte_three_i;
  logic [ByteW-1:0]  byte_four_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [IndexW-1:0] glyph_index_o;
  logic [AddrW-1:0]  rom_address_o;

  glyph_t expected_glyphs[$];
  int     mismatches = 0;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_request;
  int     hold_len;
  int     hold_served = 0;
  int     hold_left = 0;

  font_rom_glyph_address_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .font_base_i   (font_base_i),
    .glyph_bytes_i (glyph_bytes_i),
    .code_high_i   (code_high_i),
    .code_low_i    (code_low_i),
    .byte_three_i  (byte_three_i),
    .byte_four_i   (byte_four_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .glyph_index_o (glyph_index_o),
    .rom_address_o (rom_address_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction

  function automatic logic [31:0] close_trail_gap(input logic [31:0] b);
    return (b > TrailGap) ? b - 32'd1 : b;
  endfunction

  function automatic logic [31:0] gb_glyph_number(input logic [31:0] c1, c2, c3, c4,
                                                  input logic four_byte);
    logic [31:0] h;
    h = '0;
    if (c2 == TrailGap) return '0;
    // sections 1 and 5 first; a later match below overrides them
    if (c1 >= 32'hA1 && c1 <= 32'hA9 && c2 >= 32'hA1) begin
      h = (c1 - 32'hA1) * Sec1Row + (c2 - 32'hA1);
    end else if (c1 >= 32'hA8 && c1 <= 32'hA9 && c2 < 32'hA1) begin
      h = (c1 - 32'hA8) * Sec45Row + (close_trail_gap(c2) - 32'h40) + Sec5Start;
    end
    if (c1 >= 32'hB0 && c1 <= 32'hF7 && c2 >= 32'hA1) begin
      h = (c1 - 32'hB0) * Sec1Row + (c2 - 32'hA1) + Sec2Start;
    end else if (c1 < 32'hA1 && c1 >= 32'h81 && c2 >= 32'h40) begin
      h = (c1 - 32'h81) * Sec3Row + (close_trail_gap(c2) - 32'h40) + Sec3Start;
    end else if (c1 >= 32'hAA && c2 < 32'hA1) begin
      h = (c1 - 32'hAA) * Sec45Row + (close_trail_gap(c2) - 32'h40) + Sec4Start;
    end else if (four_byte && c1 == 32'h81 && c2 >= 32'h39) begin
      h = FourStart + (c3 - Area1Lead3) * 32'd10 + c4 - 32'h39;
    end else if (four_byte && c1 == 32'h82) begin
      h = FourStart + Area2Skip + (c2 - 32'h30) * Area2Stride
          + (c3 - 32'h81) * 32'd10 + c4 - 32'h30;
    end
    return h;
  endfunction

  function automatic glyph_t predict_glyph(input code_beat_t b);
    glyph_t      g;
    logic [15:0] code;
    logic [31:0] idx;
    logic [31:0] addr;
    code = {b.code_high, b.code_low};
    if (b.mode == ModeAsciiSwap) begin
      case (code)
        ColonCode:      code = SemicolonCode;
        SemicolonCode:  code = ColonCode;
        CaretCode:      code = UnderscoreCode;
        UnderscoreCode: code = CaretCode;
        default: ;
      endcase
    end
    if (b.mode == ModeAscii || b.mode == ModeAsciiSwap)
      idx = {16'd0, code} - FirstPrintable;
    else
      idx = gb_glyph_number({24'd0, b.code_high}, {24'd0, b.code_low},
                            {24'd0, b.byte_three}, {24'd0, b.byte_four},
                            b.mode == ModeGb16);
    addr = {8'd0, b.font_base} + idx * {24'd0, b.glyph_bytes};
    g.src         = b;
    g.glyph_index = idx;
    g.rom_address = addr[AddrW-1:0];
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // result side

  always @(posedge clk_i) begin
    if (hold_request != hold_served) begin
      hold_left   = hold_len;
      hold_served = hold_request;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    glyph_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: index %08h addr %06h", glyph_index_o, rom_address_o);
      end else begin
        want = expected_glyphs.pop_front();
        if (glyph_index_o !== want.glyph_index || rom_address_o !== want.rom_address) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch mode %0d code %02h %02h %02h %02h base %06h bytes %0d:",
                     want.src.mode, want.src.code_high, want.src.code_low,
                     want.src.byte_three, want.src.byte_four, want.src.font_base,
                     want.src.glyph_bytes);
            $display("  index exp %08h got %08h, addr exp %06h got %06h",
                     want.glyph_index, glyph_index_o, want.rom_address, rom_address_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus

  task automatic send_beat(input code_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= b.mode;
    font_base_i   <= b.font_base;
    glyph_bytes_i <= b.glyph_bytes;
    code_high_i   <= b.code_high;
    code_low_i    <= b.code_low;
    byte_three_i  <= b.byte_three;
    byte_four_i   <= b.byte_four;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_glyphs.push_back(predict_glyph(b));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk_i);
  endtask

  function automatic code_beat_t code_beat(input logic [1:0] mode,
                                           input logic [7:0] c1, c2, c3, c4);
    code_beat_t b;
    b.mode        = mode;
    b.font_base   = AddrW'($urandom());
    b.glyph_bytes = ByteW'($urandom());
    b.code_high   = c1;
    b.code_low    = c2;
    b.byte_three  = c3;
    b.byte_four   = c4;
    return b;
  endfunction

  function automatic code_beat_t random_code_beat();
    code_beat_t b;
    b = code_beat(2'($urandom()), 8'($urandom()), 8'($urandom()),
                  8'($urandom()), 8'($urandom()));
    case ($urandom_range(0, 5))
      0: b.glyph_bytes = 8'hFF;
      1: b.glyph_bytes = 8'($urandom_range(0, 2));
      2: b.glyph_bytes = 8'(24 + 8 * $urandom_range(0, 6));
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) b.font_base = $urandom_range(0, 1) ? '1 : '0;
    if (b.mode == ModeAscii || b.mode == ModeAsciiSwap) begin
      case ($urandom_range(0, 3))
        0: begin
          b.code_high = 8'h00;
          b.code_low  = 8'($urandom_range(0, 1) ? $urandom_range(8'h3A, 8'h3B)
                                                 : $urandom_range(8'h5E, 8'h5F));
        end
        1: b.code_high = 8'h00;
        default: ;
      endcase
    end else begin
      // mostly well-formed codes aimed at one section each
      case ($urandom_range(0, 9))
        0: begin b.code_high = 8'($urandom_range(8'hA1, 8'hA9));
                 b.code_low  = 8'($urandom_range(8'hA1, 8'hFF)); end
        1: begin b.code_high = 8'($urandom_range(8'hA8, 8'hA9));
                 b.code_low  = 8'($urandom_range(8'h40, 8'hA0)); end
        2: begin b.code_high = 8'($urandom_range(8'hB0, 8'hF7));
                 b.code_low  = 8'($urandom_range(8'hA1, 8'hFF)); end
        3: begin b.code_high = 8'($urandom_range(8'h81, 8'hA0));
                 b.code_low  = 8'($urandom_range(8'h40, 8'hFF)); end
        4: begin b.code_high = 8'($urandom_range(8'hAA, 8'hFF));
                 b.code_low  = 8'($urandom_range(8'h40, 8'hA0)); end
        5: begin b.code_high = 8'h81;
                 b.code_low  = 8'($urandom_range(8'h39, 8'h3F));
                 if ($urandom_range(0, 3) != 0) begin
                   b.byte_three = 8'($urandom_range(8'hEE, 8'hFE));
                   b.byte_four  = 8'($urandom_range(8'h30, 8'h39));
                 end
           end
        6: begin b.code_high = 8'h82;
                 b.code_low  = 8'($urandom_range(8'h30, 8'h3F));
                 if ($urandom_range(0, 3) != 0) begin
                   b.byte_three = 8'($urandom_range(8'h81, 8'hFE));
                   b.byte_four  = 8'($urandom_range(8'h30, 8'h39));
                 end
           end
        7: b.code_low = 8'h7F;
        default: ;
      endcase
    end
    return b;
  endfunction

  task automatic test_directed();
    code_beat_t b;
    // ascii wrap below the first printable code, first printable, top code
    send_beat(code_beat(ModeAscii, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(code_beat(ModeAscii, 8'h00, 8'h20, 8'hFF, 8'hFF));
    send_beat(code_beat(ModeAscii, 8'hFF, 8'hFF, 8'h00, 8'h00));
    // symbol swap, and the same codes without it
    send_beat(code_beat(ModeAsciiSwap, 8'h00, 8'h3A, 8'h00, 8'h00));
    send_beat(code_beat(ModeAsciiSwap, 8'h00, 8'h3B, 8'h00, 8'h00));
    send_beat(code_beat(ModeAsciiSwap, 8'h00, 8'h5E, 8'h00, 8'h00));
    send_beat(code_beat(ModeAsciiSwap, 8'h00, 8'h5F, 8'h00, 8'h00));
    send_beat(code_beat(ModeAsciiSwap, 8'h01, 8'h3A, 8'h00, 8'h00));
    send_beat(code_beat(ModeAscii, 8'h00, 8'h3A, 8'h00, 8'h00));
    // trail byte 0x7F gives glyph zero
    send_beat(code_beat(ModeGb12, 8'hB0, 8'h7F, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb16, 8'h81, 8'h7F, 8'hEE, 8'h39));
    // section corners
    send_beat(code_beat(ModeGb12, 8'hA1, 8'hA1, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb16, 8'hA9, 8'hFE, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb12, 8'hA8, 8'h40, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb16, 8'hA9, 8'h80, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb12, 8'hB0, 8'hA1, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb16, 8'hF7, 8'hFE, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb12, 8'h81, 8'h40, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb16, 8'hA0, 8'hFE, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb12, 8'hAA, 8'h40, 8'h00, 8'h00));
    send_beat(code_beat(ModeGb16, 8'hFE, 8'hA0, 8'h00, 8'h00));
    // four-byte areas, only honored by the 16x16 kind; offsets below start wrap
    send_beat(code_beat(ModeGb16, 8'h81, 8'h39, 8'hEE, 8'h39));
    send_beat(code_beat(ModeGb16, 8'h82, 8'h30, 8'h81, 8'h30));
    send_beat(code_beat(ModeGb12, 8'h82, 8'h35, 8'h90, 8'h31));
    send_beat(code_beat(ModeGb16, 8'h82, 8'h00, 8'h00, 8'h00));
    // no section, then address wrap at full base and glyph size, then zero base and size
    send_beat(code_beat(ModeGb12, 8'h80, 8'h20, 8'h00, 8'h00));
    b = code_beat(ModeGb16, 8'hF7, 8'hFE, 8'hFF, 8'hFF);
    b.font_base   = '1;
    b.glyph_bytes = '1;
    send_beat(b);
    b = code_beat(ModeAscii, 8'h00, 8'h00, 8'h00, 8'h00);
    b.font_base   = '0;
    b.glyph_bytes = '0;
    send_beat(b);
  endtask

  task automatic test_random(input int n, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) send_beat(random_code_beat());
  endtask

  // receiver stalls long enough for the pipeline to fill and block its input
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 10;
    hold_len      = 300;
    hold_request++;
    repeat (60) send_beat(random_code_beat());
  endtask

  // sender stops until every beat has come out, then resumes
  task automatic test_sender_pause();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    repeat (20) send_beat(random_code_beat());
    wait_results_drained();
    repeat (20) send_beat(random_code_beat());
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = ModeAscii;
    font_base_i   = '0;
    glyph_bytes_i = '0;
    code_high_i   = '0;
    code_low_i    = '0;
    byte_three_i  = '0;
    byte_four_i   = '0;
    send_idle_pct = 28;
    recv_idle_pct = 61;
    hold_request  = 0;
    hold_len      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(210, 28, 61);
    test_random(210, 61, 28);
    test_output_stall();
    test_sender_pause();
    test_random(210, 0, 0);

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_glyphs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
